// ===== src/lfpd_pkg.sv =====
package lfpd_pkg;

    localparam int SENSOR_COUNT = 8;
    localparam int SENSOR_W     = 8;
    // only sensors that fit the input field can ever be active
    localparam int ACTIVE_N     = (SENSOR_COUNT < SENSOR_W) ? SENSOR_COUNT : SENSOR_W;
    localparam int CNT_W        = $clog2(ACTIVE_N + 1);
    localparam int SUM_W        = $clog2(ACTIVE_N * (ACTIVE_N - 1) / 2 + 1);
    localparam int MEAN_W       = $clog2(ACTIVE_N);

    localparam int ERR_W        = 3;
    localparam int DIFF_W       = ERR_W + 1;
    localparam int GAIN_W       = 16;
    localparam int INT_W        = 16;
    localparam int MUL_N        = INT_W;
    localparam int MUL_CNT_W    = $clog2(MUL_N);
    localparam int HI_W         = GAIN_W + 4;
    localparam int ACC_W        = HI_W + MUL_N;
    localparam int FRAC_W       = 8;
    localparam int PID_W        = 10;
    localparam int DUTY_W       = 8;
    localparam int SUMD_W       = PID_W + 1;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED  = 3'd4;

    localparam logic signed [GAIN_W-1:0] GAIN_P_RST     = 16'sd2560;
    localparam logic signed [GAIN_W-1:0] GAIN_I_RST     = 16'sd0;
    localparam logic signed [GAIN_W-1:0] GAIN_D_RST     = 16'sd0;
    localparam logic        [DUTY_W-1:0] BASE_SPEED_RST = 8'd25;
    localparam logic        [DUTY_W-1:0] MAX_SPEED_RST  = 8'd255;

    localparam logic [MEAN_W-1:0] MEAN_MID   = MEAN_W'(3);
    localparam logic [ERR_W-1:0]  ERR_OFS_LO = ERR_W'(3);
    localparam logic [ERR_W-1:0]  ERR_OFS_HI = ERR_W'(4);

    localparam logic signed [PID_W-1:0] PID_MAX = {1'b0, {(PID_W-1){1'b1}}};
    localparam logic signed [PID_W-1:0] PID_MIN = {1'b1, {(PID_W-1){1'b0}}};
    localparam logic signed [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
    localparam logic signed [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};

    typedef struct packed {
        logic                     start;
        logic signed [ERR_W-1:0]  err;
        logic signed [DIFF_W-1:0] diff;
        logic signed [INT_W-1:0]  isum;
    } t_mac_req;

    typedef struct packed {
        logic                    done;
        logic signed [ACC_W-1:0] acc;
    } t_mac_rsp;

endpackage

// ===== src/lfpd_mac.sv =====
module lfpd_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic signed [lfpd_pkg::GAIN_W-1:0] i_gain_p,
    input  logic signed [lfpd_pkg::GAIN_W-1:0] i_gain_i,
    input  logic signed [lfpd_pkg::GAIN_W-1:0] i_gain_d,
    input  lfpd_pkg::t_mac_req                 i_req,
    output lfpd_pkg::t_mac_rsp                 o_rsp
);
    import lfpd_pkg::*;

    // serial shift-add: one multiplier bit of each term per cycle,
    // last bit carries negative weight
    logic                     r_busy, n_busy;
    logic                     r_done, n_done;
    logic [MUL_CNT_W-1:0]     r_cnt, n_cnt;
    logic signed [ERR_W-1:0]  r_me, n_me;
    logic signed [DIFF_W-1:0] r_md, n_md;
    logic signed [INT_W-1:0]  r_mi, n_mi;
    logic signed [HI_W-1:0]   r_hi, n_hi;
    logic [MUL_N-1:0]         r_lo, n_lo;

    logic signed [HI_W-1:0] w_term;
    logic signed [HI_W-1:0] w_sum;
    logic                   w_last;

    always_comb begin
        w_term = '0;
        if (r_me[0]) w_term = w_term + HI_W'(i_gain_p);
        if (r_mi[0]) w_term = w_term + HI_W'(i_gain_i);
        if (r_md[0]) w_term = w_term + HI_W'(i_gain_d);
        w_last = (r_cnt == MUL_CNT_W'(MUL_N - 1));
        w_sum  = w_last ? (r_hi - w_term) : (r_hi + w_term);
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_me   = r_me;
        n_md   = r_md;
        n_mi   = r_mi;
        n_hi   = r_hi;
        n_lo   = r_lo;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_me   = i_req.err;
            n_md   = i_req.diff;
            n_mi   = i_req.isum;
            n_hi   = '0;
            n_lo   = '0;
        end else if (r_busy) begin
            n_me  = r_me >>> 1;
            n_md  = r_md >>> 1;
            n_mi  = r_mi >>> 1;
            n_hi  = w_sum >>> 1;
            n_lo  = {w_sum[0], r_lo[MUL_N-1:1]};
            n_cnt = r_cnt + 1'b1;
            if (w_last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_me <= n_me;
        r_md <= n_md;
        r_mi <= n_mi;
        r_hi <= n_hi;
        r_lo <= n_lo;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.acc  = {r_hi, r_lo};

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("mac started while busy");

endmodule

// ===== src/line_follow_pid_drive.sv =====
// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_stall   i_line_sensors
// out      output     o_out_valid / i_out_stall o_left_duty, o_right_duty, o_line_seen
// cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A transaction passes through the sensor scan (one sensor a cycle), the bit-serial mean
// division, skipped when no sensor is active, the error and integral update, the shared
// serial multiply-accumulate, and the clamping of the PID term and the duties. No new
// transaction is accepted until the previous one has reached the output register; a stalled
// result holds the block in its last step. Synchronous active-low reset restores the gains,
// speeds, error and integral.
module line_follow_pid_drive (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [lfpd_pkg::SENSOR_W-1:0]       i_line_sensors,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [lfpd_pkg::DUTY_W-1:0]         o_left_duty,
    output logic [lfpd_pkg::DUTY_W-1:0]         o_right_duty,
    output logic                                o_line_seen,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import lfpd_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SCAN = 7'b0000010,
        S_DIV  = 7'b0000100,
        S_ERR  = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_PID  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [ACTIVE_N-1:0]     r_sens, n_sens;
    logic [SUM_W-1:0]        r_sum, n_sum;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [CNT_W-1:0]        r_rem, n_rem;
    logic                    r_seen, n_seen;
    logic signed [ERR_W-1:0] r_prev, n_prev;
    logic signed [INT_W-1:0] r_integral, n_integral;
    logic signed [PID_W-1:0] r_pid, n_pid;
    logic                    r_out_valid, n_out_valid;
    logic [DUTY_W-1:0]       r_left, n_left;
    logic [DUTY_W-1:0]       r_right, n_right;
    logic                    r_line_seen, n_line_seen;

    logic signed [GAIN_W-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic [DUTY_W-1:0]        r_base, r_max;

    t_mac_req w_req;
    t_mac_rsp w_rsp;

    logic [CNT_W:0]             w_trial;
    logic                       w_qbit;
    logic [MEAN_W-1:0]          w_mean;
    logic signed [ERR_W-1:0]    w_err;
    logic signed [INT_W:0]      w_isum_wide;
    logic signed [INT_W-1:0]    w_isum;
    logic signed [DIFF_W-1:0]   w_diff;
    logic signed [ACC_W-FRAC_W-1:0] w_quot;
    logic signed [SUMD_W-1:0]   w_lsum, w_rsum;
    logic                       w_out_free;

    function automatic logic [DUTY_W-1:0] clamp_duty(
        input logic signed [SUMD_W-1:0] v,
        input logic [DUTY_W-1:0]        vmax
    );
        logic [DUTY_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed({{(SUMD_W-DUTY_W){1'b0}}, vmax})) begin
            res = vmax;
        end else begin
            res = v[DUTY_W-1:0];
        end
        return res;
    endfunction

    always_comb begin
        w_trial = {r_rem, r_sum[SUM_W-1]};
        w_qbit  = (w_trial >= {1'b0, r_count});

        w_mean = r_sum[MEAN_W-1:0];
        if (!r_seen) begin
            w_err = r_prev;
        end else if (w_mean > MEAN_MID) begin
            w_err = ERR_W'(w_mean) - ERR_OFS_HI;
        end else begin
            w_err = ERR_W'(w_mean) - ERR_OFS_LO;
        end

        w_isum_wide = (INT_W+1)'(r_integral) + (INT_W+1)'(w_err);
        if (w_isum_wide[INT_W] != w_isum_wide[INT_W-1]) begin
            w_isum = w_isum_wide[INT_W] ? INT_MIN : INT_MAX;
        end else begin
            w_isum = w_isum_wide[INT_W-1:0];
        end
        w_diff = DIFF_W'(w_err) - DIFF_W'(r_prev);

        // divide by 2^8, truncating toward zero
        w_quot = w_rsp.acc[ACC_W-1:FRAC_W];
        if (w_rsp.acc[ACC_W-1] && (|w_rsp.acc[FRAC_W-1:0])) begin
            w_quot = w_quot + 1'b1;
        end

        w_lsum = $signed({{(SUMD_W-DUTY_W){1'b0}}, r_base}) - SUMD_W'(r_pid);
        w_rsum = $signed({{(SUMD_W-DUTY_W){1'b0}}, r_base}) + SUMD_W'(r_pid);
        w_out_free = !r_out_valid || !i_out_stall;
    end

    assign w_req.start = (r_state == S_ERR);
    assign w_req.err   = w_err;
    assign w_req.diff  = w_diff;
    assign w_req.isum  = w_isum;

    lfpd_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_gain_p (r_gain_p),
        .i_gain_i (r_gain_i),
        .i_gain_d (r_gain_d),
        .i_req    (w_req),
        .o_rsp    (w_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_sens      = r_sens;
        n_sum       = r_sum;
        n_count     = r_count;
        n_rem       = r_rem;
        n_seen      = r_seen;
        n_prev      = r_prev;
        n_integral  = r_integral;
        n_pid       = r_pid;
        n_out_valid = r_out_valid;
        n_left      = r_left;
        n_right     = r_right;
        n_line_seen = r_line_seen;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_sens  = i_line_sensors[ACTIVE_N-1:0];
                    n_cnt   = '0;
                    n_sum   = '0;
                    n_count = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_sens[0]) begin
                    n_sum   = r_sum + SUM_W'(r_cnt);
                    n_count = r_count + 1'b1;
                end
                n_sens = r_sens >> 1;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ACTIVE_N - 1)) begin
                    n_seen  = (n_count != '0);
                    n_cnt   = '0;
                    n_rem   = '0;
                    n_state = (n_count != '0) ? S_DIV : S_ERR;
                end
            end
            S_DIV: begin
                n_rem = w_qbit ? CNT_W'(w_trial - {1'b0, r_count}) : w_trial[CNT_W-1:0];
                n_sum = SUM_W'({r_sum, w_qbit});
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SUM_W - 1)) begin
                    n_state = S_ERR;
                end
            end
            S_ERR: begin
                n_prev     = w_err;
                n_integral = w_isum;
                n_state    = S_MUL;
            end
            S_MUL: begin
                if (w_rsp.done) begin
                    n_state = S_PID;
                end
            end
            S_PID: begin
                if (w_quot > (ACC_W-FRAC_W)'(PID_MAX)) begin
                    n_pid = PID_MAX;
                end else if (w_quot < (ACC_W-FRAC_W)'(PID_MIN)) begin
                    n_pid = PID_MIN;
                end else begin
                    n_pid = w_quot[PID_W-1:0];
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_left      = clamp_duty(w_lsum, r_max);
                    n_right     = clamp_duty(w_rsum, r_max);
                    n_line_seen = r_seen;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_prev      <= '0;
            r_integral  <= '0;
            r_out_valid <= 1'b0;
            r_gain_p    <= GAIN_P_RST;
            r_gain_i    <= GAIN_I_RST;
            r_gain_d    <= GAIN_D_RST;
            r_base      <= BASE_SPEED_RST;
            r_max       <= MAX_SPEED_RST;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_prev      <= n_prev;
            r_integral  <= n_integral;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_GAIN_P:     r_gain_p <= i_cfg_data;
                    REG_GAIN_I:     r_gain_i <= i_cfg_data;
                    REG_GAIN_D:     r_gain_d <= i_cfg_data;
                    REG_BASE_SPEED: r_base   <= i_cfg_data[DUTY_W-1:0];
                    REG_MAX_SPEED:  r_max    <= i_cfg_data[DUTY_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sens      <= n_sens;
        r_sum       <= n_sum;
        r_count     <= n_count;
        r_rem       <= n_rem;
        r_seen      <= n_seen;
        r_pid       <= n_pid;
        r_left      <= n_left;
        r_right     <= n_right;
        r_line_seen <= n_line_seen;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_left_duty  = r_left;
    assign o_right_duty = r_right;
    assign o_line_seen  = r_line_seen;
    assign o_cfg_ready  = 1'b1;

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prev != ERR_W'(4))
        else $error("stored error out of range");

    a_err_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ERR && !r_seen) |=> (r_prev == $past(r_prev)))
        else $error("error changed with no line seen");

    a_mac_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_MUL))
        else $error("mac done outside multiply step");

    a_out_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && i_out_stall) |=> (r_state == S_OUT))
        else $error("result overwrote a pending transaction");

endmodule

// ===== tb/tb_line_follow_pid_drive.sv =====
`timescale 1ns / 1ps

module tb_line_follow_pid_drive;
    import lfpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int REPORT_MAX     = 10;

    typedef enum {TRACK_MIX, RAMP_RIGHT, RAMP_LEFT} t_pattern;

    typedef struct packed {
        logic [DUTY_W-1:0] left;
        logic [DUTY_W-1:0] right;
        logic              seen;
    } t_drive;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [SENSOR_W-1:0]   i_line_sensors = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [DUTY_W-1:0]     o_left_duty;
    logic [DUTY_W-1:0]     o_right_duty;
    logic                  o_line_seen;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    line_follow_pid_drive i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_line_sensors (i_line_sensors),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_left_duty    (o_left_duty),
        .o_right_duty   (o_right_duty),
        .o_line_seen    (o_line_seen),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of the registers and loop state
    int kp, ki, kd, base_spd, max_spd;
    int err_last, err_sum;

    logic [SENSOR_W-1:0] sensor_backlog[$];
    t_drive              drive_due[$];
    int                  idle_pct;
    int                  fault_cnt;
    int                  quiet_cycles = 0;
    bit                  in_took = 1'b0;

    function automatic logic [DUTY_W-1:0] clamp_duty(input longint v);
        if (v < 0)
            return '0;
        if (v > max_spd)
            return DUTY_W'(max_spd);
        return DUTY_W'(v);
    endfunction

    function automatic t_drive predict_drive(input logic [SENSOR_W-1:0] sensors);
        int     total;
        int     active;
        int     mean;
        int     err;
        longint acc;
        longint pid;
        t_drive r;
        total  = 0;
        active = 0;
        for (int k = 0; k < SENSOR_COUNT && k < SENSOR_W; k++) begin
            if (sensors[k]) begin
                total  += k;
                active += 1;
            end
        end
        if (active > 0) begin
            mean = total / active;
            err  = (mean <= 3) ? mean - 3 : mean - 4;
        end else begin
            err = err_last;
        end
        err_sum += err;
        if (err_sum > 32767)
            err_sum = 32767;
        if (err_sum < -32768)
            err_sum = -32768;
        acc = longint'(kp) * err + longint'(ki) * err_sum + longint'(kd) * (err - err_last);
        pid = acc / 256;
        err_last = err;
        r.left  = clamp_duty(longint'(base_spd) - pid);
        r.right = clamp_duty(longint'(base_spd) + pid);
        r.seen  = (active > 0);
        return r;
    endfunction

    function automatic logic [SENSOR_W-1:0] draw_sensors(input t_pattern kind);
        int r;
        int w;
        r = $urandom_range(99);
        case (kind)
            RAMP_RIGHT: return (r < 80) ? SENSOR_W'(8'h80) : '0;
            RAMP_LEFT: begin
                if (r < 45)
                    return SENSOR_W'(8'h01);
                return (r < 80) ? SENSOR_W'(8'h03) : '0;
            end
            default: begin
                if (r < 15)
                    return '0;
                if (r < 70) begin
                    w = $urandom_range(1, 3);
                    return SENSOR_W'(((1 << w) - 1) << $urandom_range(0, SENSOR_W - w));
                end
                return SENSOR_W'($urandom_range(0, (1 << SENSOR_W) - 1));
            end
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain(input int span);
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 16'h8000;
        if (r == 1)
            return 16'h7fff;
        return CFG_DATA_W'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_speed();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        if (r == 1)
            return CFG_DATA_W'(8'hff);
        return CFG_DATA_W'($urandom_range(0, 255));
    endfunction

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_took) begin
            if (sensor_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
                i_in_valid     <= 1'b1;
                i_line_sensors <= sensor_backlog.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= (idle_pct > 0) && ($urandom_range(99) < idle_pct);
    end

    always @(posedge i_clk) begin
        in_took = i_rst_n && i_in_valid && !o_in_stall;
        if (in_took)
            drive_due.push_back(predict_drive(i_line_sensors));
    end

    // result monitor
    always @(posedge i_clk) begin
        t_drive got;
        t_drive want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_left_duty, o_right_duty, o_line_seen};
            if (drive_due.size() == 0) begin
                fault_cnt++;
                if (fault_cnt <= REPORT_MAX)
                    $display("unexpected result: left %0d right %0d seen %0b",
                             got.left, got.right, got.seen);
            end else begin
                want = drive_due.pop_front();
                if (got.left !== want.left || got.right !== want.right
                        || got.seen !== want.seen) begin
                    fault_cnt++;
                    if (fault_cnt <= REPORT_MAX)
                        $display("mismatch: expected left %0d right %0d seen %0b, %s %0d %0d %0b",
                                 want.left, want.right, want.seen, "got",
                                 got.left, got.right, got.seen);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout with %0d results outstanding", drive_due.size());
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            REG_GAIN_P:     kp = $signed(data);
            REG_GAIN_I:     ki = $signed(data);
            REG_GAIN_D:     kd = $signed(data);
            REG_BASE_SPEED: base_spd = int'(data[DUTY_W-1:0]);
            REG_MAX_SPEED:  max_spd = int'(data[DUTY_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic program_drive(input logic [CFG_DATA_W-1:0] gp, input logic [CFG_DATA_W-1:0] gi,
                                 input logic [CFG_DATA_W-1:0] gd, input logic [CFG_DATA_W-1:0] base,
                                 input logic [CFG_DATA_W-1:0] top);
        write_reg(REG_GAIN_P, gp);
        write_reg(REG_GAIN_I, gi);
        write_reg(REG_GAIN_D, gd);
        write_reg(REG_BASE_SPEED, base);
        write_reg(REG_MAX_SPEED, top);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(posedge i_clk);
        while (sensor_backlog.size() != 0 || i_in_valid || drive_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_batch(input int n, input t_pattern kind);
        repeat (n)
            sensor_backlog.push_back(draw_sensors(kind));
        drain();
    endtask

    initial begin
        logic [SENSOR_W-1:0] probes[$];
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        idle_pct       = 30;
        fault_cnt      = 0;
        kp       = int'(GAIN_P_RST);
        ki       = int'(GAIN_I_RST);
        kd       = int'(GAIN_D_RST);
        base_spd = int'(BASE_SPEED_RST);
        max_spd  = int'(MAX_SPEED_RST);
        err_last = 0;
        err_sum  = 0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset gains: no line at start, outermost sensors, reuse, mean of 3 and 4
        probes = {8'h00, 8'h01, 8'h80, 8'h00, 8'hff, 8'h08, 8'h10, 8'h18,
                  8'h03, 8'hc0, 8'h00, 8'h55, 8'haa};
        foreach (probes[k])
            sensor_backlog.push_back(probes[k]);
        drain();

        // extremes, zero top speed forces both duties to zero
        program_drive(16'h7fff, 16'h8000, 16'h7fff, 16'h00ff, 16'h0000);
        for (int k = REG_MAX_SPEED + 1; k < (1 << CFG_IDX_W); k++)
            write_reg(CFG_IDX_W'(k), '1);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        probes = {8'h01, 8'h80, 8'h00, 8'h7e, 8'h81};
        foreach (probes[k])
            sensor_backlog.push_back(probes[k]);
        drain();

        program_drive(16'h8000, 16'h7fff, 16'h8000, 16'h0000, 16'h00ff);
        probes = {8'h80, 8'h01, 8'h00, 8'h3c, 8'he7, 8'h02};
        foreach (probes[k])
            sensor_backlog.push_back(probes[k]);
        drain();

        repeat (6) begin
            program_drive(pick_gain(3000), pick_gain(40), pick_gain(6000),
                          pick_speed(), pick_speed());
            run_batch(230, TRACK_MIX);
        end

        // integral ramps both ways with no idling, small integral gain keeps it visible
        idle_pct = 0;
        program_drive(16'h0000, 16'h0001, 16'h0000, 16'h0080, 16'h00ff);
        run_batch(200, RAMP_RIGHT);
        run_batch(150, RAMP_LEFT);
        idle_pct = 30;
        run_batch(50, TRACK_MIX);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fault_cnt == 0 && drive_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== line_follow_pid_drive.f =====
src/lfpd_pkg.sv
src/lfpd_mac.sv
src/line_follow_pid_drive.sv
tb/tb_line_follow_pid_drive.sv
